// ----- rtl/core/tns_pkg.sv -----
package tns_pkg;

  typedef struct packed {
    logic        is_real;
    logic [31:0] value;
  } entry_t;

  // item travelling between cells; disp marks an item pushed out of a cell
  typedef struct packed {
    logic   valid;
    logic   disp;
    entry_t entry;
  } link_t;

  // contents held by a cell
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_UNLOAD = 3'b100
  } state_t;

  // integers before reals, then signed order via flipped sign bit
  function automatic logic [32:0] order_key(entry_t e);
    return {e.is_real, ~e.value[31], e.value[30:0]};
  endfunction

endpackage

// ----- rtl/core/tns_cell.sv -----
module tns_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  tns_pkg::link_t   link_in,
  input  tns_pkg::slot_t   shift_in,
  output tns_pkg::link_t   link_out,
  output tns_pkg::slot_t   held
);

  logic swap;

  // a fresh item passes an equal key; a pushed item was ahead, so it takes the slot
  always_comb begin
    swap = (tns_pkg::order_key(held.entry) > tns_pkg::order_key(link_in.entry)) ||
           (link_in.disp &&
            (tns_pkg::order_key(held.entry) == tns_pkg::order_key(link_in.entry)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid     <= 1'b0;
      link_out.valid <= 1'b0;
    end else if (shift) begin
      held           <= shift_in;
      link_out.valid <= 1'b0;
    end else if (link_in.valid) begin
      if (!held.valid) begin
        held.valid     <= 1'b1;
        held.entry     <= link_in.entry;
        link_out.valid <= 1'b0;
      end else if (swap) begin
        held.entry     <= link_in.entry;
        link_out.valid <= 1'b1;
        link_out.disp  <= 1'b1;
        link_out.entry <= held.entry;
      end else begin
        link_out <= link_in;
      end
    end else begin
      link_out.valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/tagged_number_sorter_unit.sv -----
// Tagged number sorter: collects a set of integer or Q16.16 real items and
// returns them sorted, integers first, each group ascending, ties in
// arrival order.
// Input channel (in_valid/in_stall, fields is_real, value, last): one
// transaction per cycle while loading. Items past MAX_ITEMS are dropped
// and flag overflow on every result of that set.
// The store is a chain of MAX_ITEMS insertion cells; each new item ripples
// down one cell per cycle. After the transaction with last, the chain
// settles, then unloads one item per cycle from the head cell into the
// output register whenever that register is empty or not stalled. in_stall
// is high from the last transaction until the final result has entered
// the output register.
// Output channel (out_valid/out_stall): the output register holds its
// item while out_stall is high and the chain stops shifting meanwhile.
// out_last marks the final result of a set.
// Reset (rst, synchronous) empties the chain and returns to loading.
module tagged_number_sorter_unit #(
  parameter int MAX_ITEMS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               is_real,
  input  logic signed [31:0] value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_real,
  output logic signed [31:0] out_value,
  output logic               out_last,
  output logic               overflow
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = $clog2(MAX_ITEMS);

  tns_pkg::state_t state;
  logic [CW-1:0]   count;
  logic [SW-1:0]   settle_cnt;
  logic            dropped;
  logic            accept;
  logic            full;
  logic            fire;
  tns_pkg::link_t  head_in;
  tns_pkg::link_t  links [MAX_ITEMS];
  tns_pkg::slot_t  slots [MAX_ITEMS];

  assign in_stall = (state != tns_pkg::ST_LOAD);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(MAX_ITEMS));
  assign fire     = (state == tns_pkg::ST_UNLOAD) && (!out_valid || !out_stall);

  always_comb begin
    head_in.valid         = accept && !full;
    head_in.disp          = 1'b0;
    head_in.entry.is_real = is_real;
    head_in.entry.value   = value;
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    tns_pkg::link_t l_in;
    tns_pkg::slot_t s_in;
    if (i == 0) begin : g_first
      assign l_in = head_in;
    end else begin : g_mid
      assign l_in = links[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign s_in = '0;
    end else begin : g_body
      assign s_in = slots[i+1];
    end
    tns_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (fire),
      .link_in  (l_in),
      .shift_in (s_in),
      .link_out (links[i]),
      .held     (slots[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tns_pkg::ST_LOAD;
      count      <= '0;
      settle_cnt <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        tns_pkg::ST_LOAD: begin
          if (accept) begin
            if (!full) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last) begin
              state      <= tns_pkg::ST_SETTLE;
              settle_cnt <= SW'(MAX_ITEMS - 1);
            end
          end
        end
        tns_pkg::ST_SETTLE: begin
          if (settle_cnt == '0) begin
            state <= tns_pkg::ST_UNLOAD;
          end else begin
            settle_cnt <= settle_cnt - SW'(1);
          end
        end
        tns_pkg::ST_UNLOAD: begin
          if (fire) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              state   <= tns_pkg::ST_LOAD;
              dropped <= 1'b0;
            end
          end
        end
        default: begin
          state <= tns_pkg::ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_is_real <= slots[0].entry.is_real;
      out_value   <= slots[0].entry.value;
      out_last    <= (count == CW'(1));
      overflow    <= dropped;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("stored item count exceeds capacity");

  a_no_spill: assert property (@(posedge clk) disable iff (rst)
    !links[MAX_ITEMS-1].valid)
    else $error("item pushed past the end of the chain");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    fire |-> slots[0].valid)
    else $error("unload from an empty head cell");

  a_end_of_set: assert property (@(posedge clk) disable iff (rst)
    fire && count == CW'(1) |=> state == tns_pkg::ST_LOAD && count == '0 && !slots[0].valid)
    else $error("chain not empty after final result");

  a_unload_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == tns_pkg::ST_UNLOAD |-> count != '0)
    else $error("unloading with no stored items");
`endif

endmodule

// ----- bench/tb_tagged_number_sorter_unit.sv -----
module tb_tagged_number_sorter_unit;

  localparam int SORT_DEPTH = 32;

  // tag plus raw value bits, tag in the top bit
  typedef logic [32:0] tagged_t;

  typedef struct packed {
    logic        tag;
    logic [31:0] val;
    logic        fin;
    logic        ovf;
  } sorted_item_t;

  class sort_scoreboard;
    int            capacity;
    tagged_t       held[$];
    bit            dropped;
    sorted_item_t  sorted_q[$];
    int            mismatches;
    int            results_seen;
    int            sets_closed;
    int            overflow_sets;

    function new(int cap);
      capacity = cap;
    endfunction

    // integers before reals, then signed ascending
    function bit ranks_after(tagged_t a, tagged_t b);
      if (a[32] != b[32]) return a[32] > b[32];
      return $signed(a[31:0]) > $signed(b[31:0]);
    endfunction

    function void note_input(logic tag, logic [31:0] val, logic fin);
      tagged_t      ordered[$];
      tagged_t      e;
      sorted_item_t r;
      int           j;
      if (held.size() < capacity) held.push_back({tag, val});
      else dropped = 1'b1;
      if (!fin) return;
      // stable insertion: an entry moves past another only on strictly greater
      ordered = held;
      for (int i = 1; i < ordered.size(); i++) begin
        e = ordered[i];
        j = i;
        while (j > 0 && ranks_after(ordered[j-1], e)) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = e;
      end
      foreach (ordered[k]) begin
        r.tag = ordered[k][32];
        r.val = ordered[k][31:0];
        r.fin = (k == ordered.size() - 1);
        r.ovf = dropped;
        sorted_q.push_back(r);
      end
      sets_closed++;
      if (dropped) overflow_sets++;
      held.delete();
      dropped = 1'b0;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(logic tag, logic [31:0] val, logic fin, logic ovf);
      sorted_item_t want;
      results_seen++;
      if (sorted_q.size() == 0) begin
        flag($sformatf("unexpected result tag=%0b val=%h last=%0b ovf=%0b",
                       tag, val, fin, ovf));
        return;
      end
      want = sorted_q.pop_front();
      if (want.tag !== tag || want.val !== val || want.fin !== fin || want.ovf !== ovf)
        flag($sformatf("exp tag=%0b val=%h last=%0b ovf=%0b, got tag=%0b val=%h last=%0b ovf=%0b",
                       want.tag, want.val, want.fin, want.ovf, tag, val, fin, ovf));
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               is_real;
  logic signed [31:0] value;
  logic               last;
  logic               out_valid;
  logic               out_stall;
  logic               out_is_real;
  logic signed [31:0] out_value;
  logic               out_last;
  logic               overflow;

  sort_scoreboard sb;
  int  idle_pct;
  int  stall_pct;
  int  items_sent;
  bit  pressure_go;
  bit  hold_on;

  tagged_number_sorter_unit #(.MAX_ITEMS(SORT_DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .is_real     (is_real),
    .value       (value),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_is_real (out_is_real),
    .out_value   (out_value),
    .out_last    (out_last),
    .overflow    (overflow)
  );

  always #5 clk = ~clk;

  // output side: check each transaction, then choose next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(out_is_real, out_value, out_last, overflow);
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off so the chain backs up into the input
  initial begin : hold_off_proc
    int n;
    hold_on = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_on <= 1'b1;
    for (n = 0; n < 400; n++) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("run timed out with %0d results outstanding", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input logic tag, input logic [31:0] val, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    is_real  <= tag;
    value    <= val;
    last     <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(tag, val, fin);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return 32'($urandom_range(8)) - 32'd4;  // small values force ties
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_set();
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 65)      len = $urandom_range(8, 1);
    else if (pick < 85) len = $urandom_range(31, 9);
    else if (pick < 92) len = SORT_DEPTH;
    else                len = $urandom_range(SORT_DEPTH + 8, SORT_DEPTH + 1);
    for (int k = 0; k < len; k++)
      send_item(1'($urandom_range(1)), pick_value(), k == len - 1);
  endtask

  initial begin : main_flow
    int phase_idle[4];
    int phase_stall[4];
    int goal;
    phase_idle  = '{0, 74, 0, 13};
    phase_stall = '{0, 0, 74, 13};
    sb = new(SORT_DEPTH);
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    is_real = 1'b0;
    value = '0;
    last = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    pressure_go = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single-item set
    send_item(1'b0, 32'h7fff_ffff, 1'b1);
    // extremes of the real group, integer minimum, ties, mixed arrival
    send_item(1'b1, 32'h8000_0000, 1'b0);
    send_item(1'b0, 32'h8000_0000, 1'b0);
    send_item(1'b1, 32'h7fff_ffff, 1'b0);
    send_item(1'b0, 32'h0000_0000, 1'b0);
    send_item(1'b0, 32'hffff_ffff, 1'b0);
    send_item(1'b1, 32'h0001_0000, 1'b0);
    send_item(1'b1, 32'hfffe_8000, 1'b0);
    send_item(1'b0, 32'h0000_0005, 1'b0);
    send_item(1'b0, 32'h0000_0005, 1'b0);
    send_item(1'b1, 32'h0000_0000, 1'b1);
    // mixed arrival order, equal values across the two tags, tied reals
    send_item(1'b0, 32'd3, 1'b0);
    send_item(1'b0, 32'd2, 1'b0);
    send_item(1'b1, 32'd7, 1'b0);
    send_item(1'b0, 32'd7, 1'b0);
    send_item(1'b1, 32'd7, 1'b0);
    send_item(1'b0, 32'd1, 1'b0);
    send_item(1'b0, -32'sd7, 1'b1);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) pressure_go = 1'b1;
      goal = items_sent + 88;
      while (items_sent < goal) send_random_set();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (3 * SORT_DEPTH) @(posedge clk);

    $display("%0d items in %0d sets (%0d with dropped items), %0d results compared",
             items_sent, sb.sets_closed, sb.overflow_sets, sb.results_seen);
    $display("idle mixes: none, input gaps, output stalls, both; one 400-cycle output hold");
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
